// ----- rtl/gmc_pkg.sv -----
// ----------------------------------------------------------------------------
// gmc_pkg
// Shared types and constants of the gradient map colorizer: stop register
// layout, register indexes, reset values and the stage payload structs.
// ----------------------------------------------------------------------------
package gmc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned STOP_WIDTH      = 40;
   localparam int unsigned COUNT_WIDTH     = 3;
   localparam int unsigned CHAN_WIDTH      = 8;
   localparam int unsigned CHANNELS        = 4;
   localparam int unsigned NUM_WIDTH       = 2 * CHAN_WIDTH;
   localparam int unsigned POS_LSB         = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_COUNT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_BASE  = 3'd1;

   localparam logic [COUNT_WIDTH-1:0] STOP_COUNT_RESET = 3'd3;
   localparam logic [COUNT_WIDTH-1:0] MIN_STOPS        = 3'd2;

   localparam logic [STOP_WIDTH-1:0] STOP_ZERO_RESET = 40'h33FF545454;
   localparam logic [STOP_WIDTH-1:0] STOP_ONE_RESET  = 40'h80FF492F25;
   localparam logic [STOP_WIDTH-1:0] STOP_TWO_RESET  = 40'hF2FF727272;

   typedef logic [STOP_WIDTH-1:0] stop_type;
   typedef logic [CHAN_WIDTH-1:0] chan_type;

   typedef struct packed {
      chan_type                     level;
      chan_type                     p1;
      chan_type                     p2;
      logic [CHANNELS-1:0][CHAN_WIDTH-1:0] c1;
      logic [CHANNELS-1:0][CHAN_WIDTH-1:0] c2;
      logic                         lerp;
      logic                         frame_end;
   } sel_type;

   typedef struct packed {
      logic [CHANNELS-1:0][NUM_WIDTH-1:0]  rem;
      chan_type                            div;
      logic [CHANNELS-1:0][CHAN_WIDTH-1:0] quo;
      logic                                frame_end;
   } div_type;

   function automatic stop_type stop_reset(input int unsigned idx);
      stop_type value;
      unique case (idx)
         0:       value = STOP_ZERO_RESET;
         1:       value = STOP_ONE_RESET;
         2:       value = STOP_TWO_RESET;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// ----- rtl/gmc_select.sv -----
// ----------------------------------------------------------------------------
// gmc_select
// Stop search stage: finds the last active stop below the level, pairs it
// with its successor and registers the pair.
// ----------------------------------------------------------------------------
module gmc_select #(
   parameter int unsigned MAX_STOPS = 6
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         up_valid,
   output logic                                         up_ready,
   input  gmc_pkg::chan_type                            up_level,
   input  logic                                         up_frame_end,
   input  logic [gmc_pkg::COUNT_WIDTH-1:0]              stop_count,
   input  logic [MAX_STOPS-1:0][gmc_pkg::STOP_WIDTH-1:0] stops,
   output logic                                         dn_valid,
   input  logic                                         dn_ready,
   output gmc_pkg::sel_type                             dn_data
);

   localparam logic [gmc_pkg::COUNT_WIDTH-1:0] MAX_N = gmc_pkg::COUNT_WIDTH'(MAX_STOPS);
   localparam int unsigned PL = gmc_pkg::POS_LSB;

   logic [gmc_pkg::COUNT_WIDTH-1:0] n;
   logic                            pair;
   gmc_pkg::sel_type                sel_in;
   gmc_pkg::sel_type                sel_ff;
   logic                            valid_ff;

   always_comb begin
      n = stop_count;
      if (n < gmc_pkg::MIN_STOPS) begin
         n = gmc_pkg::MIN_STOPS;
      end else if (n > MAX_N) begin
         n = MAX_N;
      end
      pair          = 1'b0;
      sel_in.level  = up_level;
      sel_in.p1     = stops[0][PL +: 8];
      sel_in.p2     = stops[0][PL +: 8];
      sel_in.c1     = stops[0][PL-1:0];
      sel_in.c2     = stops[0][PL-1:0];
      sel_in.frame_end = up_frame_end;
      for (int i = 0; i < MAX_STOPS; i++) begin
         if ((gmc_pkg::COUNT_WIDTH'(i) < n) && (stops[i][PL +: 8] < up_level)) begin
            sel_in.p1 = stops[i][PL +: 8];
            sel_in.c1 = stops[i][PL-1:0];
            if ((i + 1 < MAX_STOPS) && (gmc_pkg::COUNT_WIDTH'(i + 1) < n)) begin
               sel_in.p2 = stops[(i + 1) % MAX_STOPS][PL +: 8];
               sel_in.c2 = stops[(i + 1) % MAX_STOPS][PL-1:0];
               pair      = 1'b1;
            end else begin
               sel_in.p2 = stops[i][PL +: 8];
               sel_in.c2 = stops[i][PL-1:0];
               pair      = 1'b0;
            end
         end
      end
      sel_in.lerp = pair && (sel_in.p2 > sel_in.p1) && (sel_in.p2 >= up_level)
                    && (up_level > sel_in.p1);
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         sel_ff <= sel_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = sel_ff;

endmodule

// ----- rtl/gmc_blend.sv -----
// ----------------------------------------------------------------------------
// gmc_blend
// Weighting stage: forms the per-channel numerator c1*(p2-g) + c2*(g-p1)
// and the divisor p2-p1; a lone stop passes as its color over one.
// ----------------------------------------------------------------------------
module gmc_blend (
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   output logic             up_ready,
   input  gmc_pkg::sel_type up_data,
   output logic             dn_valid,
   input  logic             dn_ready,
   output gmc_pkg::div_type dn_data
);

   localparam int unsigned NW = gmc_pkg::NUM_WIDTH;

   gmc_pkg::chan_type wa;
   gmc_pkg::chan_type wb;
   gmc_pkg::div_type  blend_in;
   gmc_pkg::div_type  blend_ff;
   logic              valid_ff;

   always_comb begin
      wa = up_data.p2 - up_data.level;
      wb = up_data.level - up_data.p1;
      blend_in.quo       = '0;
      blend_in.frame_end = up_data.frame_end;
      if (up_data.lerp) begin
         blend_in.div = up_data.p2 - up_data.p1;
      end else begin
         blend_in.div = gmc_pkg::chan_type'(1);
      end
      for (int k = 0; k < gmc_pkg::CHANNELS; k++) begin
         if (up_data.lerp) begin
            blend_in.rem[k] = NW'(({8'd0, up_data.c1[k]} * {8'd0, wa})
                                + ({8'd0, up_data.c2[k]} * {8'd0, wb}));
         end else begin
            blend_in.rem[k] = {8'd0, up_data.c1[k]};
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         blend_ff <= blend_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = blend_ff;

endmodule

// ----- rtl/gmc_div_stage.sv -----
// ----------------------------------------------------------------------------
// gmc_div_stage
// Two restoring division steps on all four channels, quotient bits TOP_BIT
// and TOP_BIT-1.
// ----------------------------------------------------------------------------
module gmc_div_stage #(
   parameter int unsigned TOP_BIT = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   output logic             up_ready,
   input  gmc_pkg::div_type up_data,
   output logic             dn_valid,
   input  logic             dn_ready,
   output gmc_pkg::div_type dn_data
);

   localparam int unsigned NW = gmc_pkg::NUM_WIDTH;

   logic [NW-1:0]    trial;
   gmc_pkg::div_type step_in;
   gmc_pkg::div_type step_ff;
   logic             valid_ff;

   always_comb begin
      trial   = '0;
      step_in = up_data;
      for (int j = 0; j < 2; j++) begin
         trial = NW'({8'd0, up_data.div} << (TOP_BIT - j));
         for (int k = 0; k < gmc_pkg::CHANNELS; k++) begin
            if (step_in.rem[k] >= trial) begin
               step_in.rem[k]               = step_in.rem[k] - trial;
               step_in.quo[k][TOP_BIT - j]  = 1'b1;
            end
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         step_ff <= step_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = step_ff;

endmodule

// ----- rtl/gradient_map_colourize_top.sv -----
// ----------------------------------------------------------------------------
// gradient_map_colourize_top
// Gradient map: maps a pixel level through a ramp of 2 to MAX_STOPS color
// stops with per-channel linear interpolation between neighbouring stops.
//
//   channel   ports                  role
//   req       valid/ready            level and frame_end in, one item
//   rsp       valid/ready            ARGB and frame_end out, one item
//   csr       we/index/wdata         stop count and stop registers
//
// One item per cycle unless rsp stalls; stages: stop search, weighting, then four
// division stages of two quotient bits each.
// Synchronous reset clears all valid bits and loads the default ramp.
// A stall at rsp backs up stage by stage; empty stages still take items.
// ----------------------------------------------------------------------------
module gradient_map_colourize_top #(
   parameter int unsigned MAX_STOPS = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_level,
   input  logic                                  req_frame_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [7:0]                            rsp_alpha_out,
   output logic [7:0]                            rsp_red_out,
   output logic [7:0]                            rsp_green_out,
   output logic [7:0]                            rsp_blue_out,
   output logic                                  rsp_frame_end_out,
   input  logic                                  csr_we,
   input  logic [gmc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [gmc_pkg::STOP_WIDTH-1:0]        csr_wdata
);

   localparam int unsigned DIV_STAGES = 4;

   logic [gmc_pkg::COUNT_WIDTH-1:0]              stop_count_ff;
   logic [MAX_STOPS-1:0][gmc_pkg::STOP_WIDTH-1:0] stops_ff;

   logic             sel_valid;
   logic             sel_ready;
   gmc_pkg::sel_type sel_data;

   logic             dv_valid [DIV_STAGES+1];
   logic             dv_ready [DIV_STAGES+1];
   gmc_pkg::div_type dv_data  [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= gmc_pkg::STOP_COUNT_RESET;
         for (int i = 0; i < MAX_STOPS; i++) begin
            stops_ff[i] <= gmc_pkg::stop_reset(i);
         end
      end else if (csr_we) begin
         if (csr_index == gmc_pkg::CSR_STOP_COUNT) begin
            stop_count_ff <= csr_wdata[gmc_pkg::COUNT_WIDTH-1:0];
         end
         for (int i = 0; i < MAX_STOPS; i++) begin
            if (csr_index == gmc_pkg::CSR_STOP_BASE + gmc_pkg::CSR_INDEX_WIDTH'(i)) begin
               stops_ff[i] <= csr_wdata;
            end
         end
      end
   end

   gmc_select #(
      .MAX_STOPS (MAX_STOPS)
   ) u_select (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_valid),
      .up_ready     (req_ready),
      .up_level     (req_level),
      .up_frame_end (req_frame_end),
      .stop_count   (stop_count_ff),
      .stops        (stops_ff),
      .dn_valid     (sel_valid),
      .dn_ready     (sel_ready),
      .dn_data      (sel_data)
   );

   gmc_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .up_valid (sel_valid),
      .up_ready (sel_ready),
      .up_data  (sel_data),
      .dn_valid (dv_valid[0]),
      .dn_ready (dv_ready[0]),
      .dn_data  (dv_data[0])
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      gmc_div_stage #(
         .TOP_BIT (7 - 2 * s)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .up_valid (dv_valid[s]),
         .up_ready (dv_ready[s]),
         .up_data  (dv_data[s]),
         .dn_valid (dv_valid[s+1]),
         .dn_ready (dv_ready[s+1]),
         .dn_data  (dv_data[s+1])
      );
   end

   assign dv_ready[DIV_STAGES] = rsp_ready;
   assign rsp_valid            = dv_valid[DIV_STAGES];
   assign rsp_alpha_out        = dv_data[DIV_STAGES].quo[3];
   assign rsp_red_out          = dv_data[DIV_STAGES].quo[2];
   assign rsp_green_out        = dv_data[DIV_STAGES].quo[1];
   assign rsp_blue_out         = dv_data[DIV_STAGES].quo[0];
   assign rsp_frame_end_out    = dv_data[DIV_STAGES].frame_end;

`ifndef SYNTH
   a_lerp_span : assert property (@(posedge clock) disable iff (reset)
      sel_valid && sel_data.lerp |-> sel_data.p2 > sel_data.p1)
      else $error("interpolating pair without positive span");

   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      dv_valid[0] |-> dv_data[0].div != 8'd0)
      else $error("zero divisor entering divider");

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (dv_data[DIV_STAGES].rem[0] < {8'd0, dv_data[DIV_STAGES].div})
                 && (dv_data[DIV_STAGES].rem[1] < {8'd0, dv_data[DIV_STAGES].div})
                 && (dv_data[DIV_STAGES].rem[2] < {8'd0, dv_data[DIV_STAGES].div})
                 && (dv_data[DIV_STAGES].rem[3] < {8'd0, dv_data[DIV_STAGES].div}))
      else $error("final remainder not below divisor");

   a_hold_stalled : assert property (@(posedge clock) disable iff (reset)
      sel_valid && !sel_ready |=> sel_valid && $stable(sel_data))
      else $error("select stage lost a stalled item");
`endif

endmodule

// ----- test/tb_gradient_map_colourize_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gradient_map_colourize_top
// Self-checking bench for the gradient map colorizer. A scoreboard keeps its
// own copy of the stop registers, predicts the ARGB color of every accepted
// pixel and compares each returned item in order. Directed ramps hit the
// edges of the search and the register clamps; random ramps, levels and
// handshake stalls cover the rest.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [7:0] alpha;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_end;
} pixel_type;

class ramp_scoreboard;
   localparam int unsigned STOP_SLOTS = 6;

   logic [gmc_pkg::COUNT_WIDTH-1:0] count_reg;
   gmc_pkg::stop_type               stop_regs[STOP_SLOTS];
   pixel_type                       expected_pixels[$];
   int unsigned                     failures;
   int unsigned                     checked;

   function new();
      count_reg    = gmc_pkg::STOP_COUNT_RESET;
      stop_regs[0] = gmc_pkg::STOP_ZERO_RESET;
      stop_regs[1] = gmc_pkg::STOP_ONE_RESET;
      stop_regs[2] = gmc_pkg::STOP_TWO_RESET;
      stop_regs[3] = '0;
      stop_regs[4] = '0;
      stop_regs[5] = '0;
      failures     = 0;
      checked      = 0;
   endfunction

   function void write_reg(logic [gmc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                           gmc_pkg::stop_type data);
      int unsigned slot;
      slot = idx;
      if (idx == gmc_pkg::CSR_STOP_COUNT) begin
         count_reg = data[gmc_pkg::COUNT_WIDTH-1:0];
      end else if (slot - gmc_pkg::CSR_STOP_BASE < STOP_SLOTS) begin
         stop_regs[slot - gmc_pkg::CSR_STOP_BASE] = data;
      end
   endfunction

   function pixel_type ramp_colour(logic [7:0] level, logic frame_end);
      logic [31:0] colour;
      int unsigned n, lo, hi, i, k, g, p1, p2, c1, c2, v;
      g  = level;
      n  = count_reg;
      if (n < gmc_pkg::MIN_STOPS) n = gmc_pkg::MIN_STOPS;
      if (n > STOP_SLOTS) n = STOP_SLOTS;
      lo = 0;
      hi = 0;
      for (i = 0; i < n; i++) begin
         if (stop_regs[i][39:32] < g) begin
            lo = i;
            hi = (i + 1 < n) ? i + 1 : i;
         end
      end
      for (k = 0; k < gmc_pkg::CHANNELS; k++) begin
         c1 = stop_regs[lo][31 - 8*k -: 8];
         v  = c1;
         if (hi != lo) begin
            p1 = stop_regs[lo][39:32];
            p2 = stop_regs[hi][39:32];
            c2 = stop_regs[hi][31 - 8*k -: 8];
            if (p2 > p1 && p2 >= g && g > p1) begin
               v = (c1 * (p2 - g) + c2 * (g - p1)) / (p2 - p1);
            end
         end
         colour[31 - 8*k -: 8] = v[7:0];
      end
      return {colour, frame_end};
   endfunction

   function void note_pixel(logic [7:0] level, logic frame_end);
      expected_pixels = {expected_pixels, ramp_colour(level, frame_end)};
   endfunction

   function int unsigned pending();
      return expected_pixels.size();
   endfunction

   function void check_pixel(pixel_type got);
      pixel_type want;
      checked++;
      if (expected_pixels.size() == 0) begin
         failures++;
         if (failures <= 10) begin
            $display("pixel %0d: unexpected item a=%02h r=%02h g=%02h b=%02h fe=%b",
                     checked, got.alpha, got.red, got.green, got.blue, got.frame_end);
         end
         return;
      end
      want = expected_pixels.pop_front();
      if (got.alpha !== want.alpha || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.frame_end !== want.frame_end) begin
         failures++;
         if (failures <= 10) begin
            $display("pixel %0d: expected a=%02h r=%02h g=%02h b=%02h fe=%b",
                     checked, want.alpha, want.red, want.green, want.blue, want.frame_end);
            $display("          got a=%02h r=%02h g=%02h b=%02h fe=%b",
                     got.alpha, got.red, got.green, got.blue, got.frame_end);
         end
      end
   endfunction
endclass

module tb_gradient_map_colourize_top;

   localparam int unsigned MAX_STOPS     = 6;
   localparam int unsigned CYCLE_LIMIT   = 300000;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int unsigned PHASE_PIXELS  = 55;
   localparam int unsigned RANDOM_PHASES = 10;
   localparam logic [gmc_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE = 3'd7;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [7:0]                          req_level;
   logic                                req_frame_end;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [7:0]                          rsp_alpha_out;
   logic [7:0]                          rsp_red_out;
   logic [7:0]                          rsp_green_out;
   logic [7:0]                          rsp_blue_out;
   logic                                rsp_frame_end_out;
   logic                                csr_we;
   logic [gmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [gmc_pkg::STOP_WIDTH-1:0]      csr_wdata;

   ramp_scoreboard board = new();

   int unsigned cycle_count  = 0;
   int unsigned send_idle    = 0;
   int unsigned recv_idle    = 0;
   bit          hold_request = 0;
   int unsigned pixels_sent  = 0;
   int unsigned reg_writes   = 0;
   int unsigned ramps_used   = 1;

   gradient_map_colourize_top #(
      .MAX_STOPS(MAX_STOPS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_level(req_level),
      .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_alpha_out(rsp_alpha_out),
      .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .rsp_frame_end_out(rsp_frame_end_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_pixel({rsp_alpha_out, rsp_red_out, rsp_green_out, rsp_blue_out,
                            rsp_frame_end_out});
      end
   end

   initial begin
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 0;
         end else if (recv_idle != 0 && $urandom_range(1, recv_idle) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic program_reg(logic [gmc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                              gmc_pkg::stop_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(idx, data);
      reg_writes++;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [7:0] level, logic frame_end);
      if (send_idle != 0 && $urandom_range(1, send_idle) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_level     <= level;
      req_frame_end <= frame_end;
      do @(posedge clock); while (!req_ready);
      board.note_pixel(level, frame_end);
      pixels_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic random_ramp();
      int unsigned positions[$];
      int unsigned shape, i;
      shape = $urandom_range(0, 5);
      for (i = 0; i < MAX_STOPS; i++) positions = {positions, $urandom_range(0, 255)};
      if (shape != 5) positions.sort();
      if (shape == 4) positions[2] = positions[1];
      for (i = 0; i < MAX_STOPS; i++) begin
         program_reg(gmc_pkg::CSR_STOP_BASE + gmc_pkg::CSR_INDEX_WIDTH'(i),
                     {positions[i][7:0], 32'($urandom())});
      end
      program_reg(gmc_pkg::CSR_STOP_COUNT, 40'($urandom_range(0, 7)));
      if ($urandom_range(0, 3) == 0) begin
         program_reg(CSR_SPARE, {8'($urandom_range(0, 255)), 32'($urandom())});
      end
      ramps_used++;
   endtask

   initial begin
      int unsigned phase, n, j;
      logic [7:0]  level;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_level     <= '0;
      req_frame_end <= 1'b0;
      csr_we        <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default ramp: below first stop, on each stop, between, past last
      send_pixel(8'h00, 1'b0);
      send_pixel(8'h33, 1'b0);
      send_pixel(8'h34, 1'b0);
      send_pixel(8'h7F, 1'b0);
      send_pixel(8'h80, 1'b1);
      send_pixel(8'h81, 1'b0);
      send_pixel(8'hF2, 1'b0);
      send_pixel(8'hF3, 1'b0);
      send_pixel(8'hFF, 1'b1);
      drain_results();

      // full-width ramp, count above range, duplicate positions, spare index
      program_reg(gmc_pkg::CSR_STOP_BASE + 3'd0, {8'h00, 32'hFFFFFFFF});
      program_reg(gmc_pkg::CSR_STOP_BASE + 3'd1, {8'h01, 32'h00000000});
      program_reg(gmc_pkg::CSR_STOP_BASE + 3'd2, {8'h01, 32'h80808080});
      program_reg(gmc_pkg::CSR_STOP_BASE + 3'd3, {8'h7F, 32'h12345678});
      program_reg(gmc_pkg::CSR_STOP_BASE + 3'd4, {8'hFE, 32'hFFFFFFFF});
      program_reg(gmc_pkg::CSR_STOP_BASE + 3'd5, {8'hFF, 32'h00FF00FF});
      program_reg(gmc_pkg::CSR_STOP_COUNT, 40'h7);
      program_reg(CSR_SPARE, 40'hFFFFFFFFFF);
      ramps_used++;
      send_pixel(8'h00, 1'b1);
      send_pixel(8'h01, 1'b0);
      send_pixel(8'h02, 1'b0);
      send_pixel(8'h80, 1'b0);
      send_pixel(8'hFE, 1'b0);
      send_pixel(8'hFF, 1'b1);
      drain_results();

      // count below range, stops out of order
      program_reg(gmc_pkg::CSR_STOP_BASE + 3'd0, {8'hC0, 32'hFF000000});
      program_reg(gmc_pkg::CSR_STOP_BASE + 3'd1, {8'h40, 32'h00FFFFFF});
      program_reg(gmc_pkg::CSR_STOP_COUNT, 40'h0);
      ramps_used++;
      send_pixel(8'h00, 1'b0);
      send_pixel(8'h41, 1'b0);
      send_pixel(8'hC0, 1'b1);
      send_pixel(8'hC1, 1'b0);
      send_pixel(8'hFF, 1'b0);
      drain_results();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_ramp();
         if (phase >= RANDOM_PHASES - 2) begin
            send_idle = 0;
            recv_idle = 0;
         end else begin
            send_idle = $urandom_range(0, 2) * 3;
            recv_idle = $urandom_range(0, 2) * 3;
         end
         if (phase == 3) begin
            send_idle    = 0;
            hold_request = 1;
         end
         for (n = 0; n < PHASE_PIXELS; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               j     = $urandom_range(0, MAX_STOPS - 1);
               level = 8'(board.stop_regs[j][39:32] + $urandom_range(0, 2) - 1);
            end else begin
               level = 8'($urandom_range(0, 255));
            end
            send_pixel(level, $urandom_range(0, 15) == 0);
         end
         drain_results();
      end

      repeat (12) @(posedge clock);
      $display("Covered %0d pixels over %0d ramp settings with %0d register writes,",
               pixels_sent, ramps_used, reg_writes);
      $display("including stalls, a long output hold and clamped stop counts.");
      if (board.failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", board.failures);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/gmc_pkg.sv
rtl/gmc_select.sv
rtl/gmc_blend.sv
rtl/gmc_div_stage.sv
rtl/gradient_map_colourize_top.sv
test/tb_gradient_map_colourize_top.sv
